// ===== hw/rtl/jtm_pkg.sv =====
`timescale 1ns / 1ps
// Package for the JSON text minifier: item structs, scan modes, character codes
// and the single-byte classification helper. No dependencies.

package jtm_pkg;

  // Field widths fixed by the item format
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;

  // Default configuration
  localparam int unsigned MaxTextLengthDef = 65535;
  localparam int unsigned OutqDepthDef     = 4;

  // Character codes
  localparam logic [ByteW-1:0] CharNul       = 8'h00;
  localparam logic [ByteW-1:0] CharTab       = 8'h09;
  localparam logic [ByteW-1:0] CharLf        = 8'h0A;
  localparam logic [ByteW-1:0] CharCr        = 8'h0D;
  localparam logic [ByteW-1:0] CharSpace     = 8'h20;
  localparam logic [ByteW-1:0] CharQuote     = 8'h22;
  localparam logic [ByteW-1:0] CharStar      = 8'h2A;
  localparam logic [ByteW-1:0] CharSlash     = 8'h2F;
  localparam logic [ByteW-1:0] CharBackslash = 8'h5C;

  // Scanner modes
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_BSTAR  = 3'd4,
    MODE_STR    = 3'd5,
    MODE_SESC   = 3'd6,
    MODE_STOP   = 3'd7
  } mode_e;

  // Input item
  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             last_byte;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic              has_byte;
    logic [ByteW-1:0]  out_byte;
    logic              done_res;
    logic [CountW-1:0] kept_count;
  } out_item_t;

  // Up to two results per input transfer; push1 only together with push0
  typedef struct packed {
    logic      push0;
    logic      push1;
    out_item_t res0;
    out_item_t res1;
  } scan_res_t;

  // Outcome of one byte in normal text
  typedef struct packed {
    logic  keep;
    mode_e mode;
  } norm_step_t;

  function automatic norm_step_t normal_step(input logic [ByteW-1:0] b);
    norm_step_t r;
    r.keep = 1'b0;
    r.mode = MODE_NORMAL;
    priority if (b == CharNul) begin
      r.mode = MODE_STOP;
    end else if (b == CharSpace || b == CharTab || b == CharCr || b == CharLf) begin
      r.keep = 1'b0;
    end else if (b == CharSlash) begin
      r.mode = MODE_SLASH;
    end else if (b == CharQuote) begin
      r.keep = 1'b1;
      r.mode = MODE_STR;
    end else begin
      r.keep = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/jtm_scan.sv =====
`timescale 1ns / 1ps
// Byte scanner: next mode, next kept count and up to two results for one byte.
// Purely combinational; depends on jtm_pkg.

module jtm_scan #(
  parameter int unsigned MaxTextLength = jtm_pkg::MaxTextLengthDef
) (
  input  jtm_pkg::mode_e                  mode_q_i,
  input  logic [jtm_pkg::CountW-1:0]      total_q_i,
  input  jtm_pkg::in_item_t               item_i,
  output jtm_pkg::mode_e                  mode_d_o,
  output logic [jtm_pkg::CountW-1:0]      total_d_o,
  output jtm_pkg::scan_res_t              res_o
);

  localparam logic [jtm_pkg::CountW-1:0] KeepLimit =
      (MaxTextLength < 65535) ? MaxTextLength[jtm_pkg::CountW-1:0] : 16'hFFFF;

  logic [jtm_pkg::ByteW-1:0]  b;
  logic [jtm_pkg::CountW-1:0] cnt1, cnt2;
  logic                       e0, e1;
  logic [jtm_pkg::ByteW-1:0]  b0, b1;
  jtm_pkg::mode_e             mode_n;
  jtm_pkg::norm_step_t        ns;

  assign b = item_i.in_byte;

  // Saturating counts after one and two kept bytes
  assign cnt1 = (total_q_i < KeepLimit) ? total_q_i + 16'd1 : total_q_i;
  assign cnt2 = (cnt1 < KeepLimit) ? cnt1 + 16'd1 : cnt1;

  // Mode update and kept bytes
  always_comb begin
    e0     = 1'b0;
    e1     = 1'b0;
    b0     = b;
    b1     = b;
    mode_n = mode_q_i;
    ns     = jtm_pkg::normal_step(b);
    unique case (mode_q_i)
      jtm_pkg::MODE_NORMAL: begin
        e0     = ns.keep;
        mode_n = ns.mode;
      end
      jtm_pkg::MODE_SLASH: begin
        priority if (b == jtm_pkg::CharSlash) begin
          mode_n = jtm_pkg::MODE_LINE;
        end else if (b == jtm_pkg::CharStar) begin
          mode_n = jtm_pkg::MODE_BLOCK;
        end else begin
          // held slash goes out first, then the byte as normal text
          e0     = 1'b1;
          b0     = jtm_pkg::CharSlash;
          e1     = ns.keep;
          mode_n = ns.mode;
        end
      end
      jtm_pkg::MODE_LINE: begin
        priority if (b == jtm_pkg::CharNul) begin
          mode_n = jtm_pkg::MODE_STOP;
        end else if (b == jtm_pkg::CharLf) begin
          mode_n = jtm_pkg::MODE_NORMAL;
        end else begin
          mode_n = jtm_pkg::MODE_LINE;
        end
      end
      jtm_pkg::MODE_BLOCK: begin
        priority if (b == jtm_pkg::CharNul) begin
          mode_n = jtm_pkg::MODE_STOP;
        end else if (b == jtm_pkg::CharStar) begin
          mode_n = jtm_pkg::MODE_BSTAR;
        end else begin
          mode_n = jtm_pkg::MODE_BLOCK;
        end
      end
      jtm_pkg::MODE_BSTAR: begin
        priority if (b == jtm_pkg::CharNul) begin
          mode_n = jtm_pkg::MODE_STOP;
        end else if (b == jtm_pkg::CharSlash) begin
          mode_n = jtm_pkg::MODE_NORMAL;
        end else if (b == jtm_pkg::CharStar) begin
          mode_n = jtm_pkg::MODE_BSTAR;
        end else begin
          mode_n = jtm_pkg::MODE_BLOCK;
        end
      end
      jtm_pkg::MODE_STR: begin
        priority if (b == jtm_pkg::CharNul) begin
          mode_n = jtm_pkg::MODE_STOP;
        end else if (b == jtm_pkg::CharBackslash) begin
          e0     = 1'b1;
          mode_n = jtm_pkg::MODE_SESC;
        end else if (b == jtm_pkg::CharQuote) begin
          e0     = 1'b1;
          mode_n = jtm_pkg::MODE_NORMAL;
        end else begin
          e0     = 1'b1;
        end
      end
      jtm_pkg::MODE_SESC: begin
        e0     = 1'b1;
        mode_n = jtm_pkg::MODE_STR;
      end
      jtm_pkg::MODE_STOP: begin
        mode_n = jtm_pkg::MODE_STOP;
      end
      default: begin
        mode_n = mode_q_i;
      end
    endcase
  end

  // Result assembly, end-of-buffer handling
  always_comb begin
    res_o.push0               = e0;
    res_o.push1               = e1;
    res_o.res0.has_byte       = 1'b1;
    res_o.res0.out_byte       = b0;
    res_o.res0.done_res       = 1'b0;
    res_o.res0.kept_count     = cnt1;
    res_o.res1.has_byte       = 1'b1;
    res_o.res1.out_byte       = b1;
    res_o.res1.done_res       = 1'b0;
    res_o.res1.kept_count     = cnt2;
    mode_d_o                  = mode_n;
    total_d_o                 = e1 ? cnt2 : (e0 ? cnt1 : total_q_i);

    if (item_i.last_byte) begin
      // a slash still held at the end is kept; it is always the first result
      if (mode_n == jtm_pkg::MODE_SLASH) begin
        res_o.push0           = 1'b1;
        res_o.res0.out_byte   = jtm_pkg::CharSlash;
      end else if (!e0) begin
        // nothing kept: one empty result carrying the count
        res_o.push0           = 1'b1;
        res_o.res0.has_byte   = 1'b0;
        res_o.res0.out_byte   = '0;
        res_o.res0.kept_count = total_q_i;
      end
      if (e1) begin
        res_o.res1.done_res   = 1'b1;
      end else begin
        res_o.res0.done_res   = 1'b1;
      end
      mode_d_o                = jtm_pkg::MODE_NORMAL;
      total_d_o               = '0;
    end
  end

endmodule

// ===== hw/rtl/jtm_outq.sv =====
`timescale 1ns / 1ps
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Flip-flop storage; depends on jtm_pkg.

module jtm_outq #(
  parameter int unsigned Depth = jtm_pkg::OutqDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jtm_pkg::scan_res_t push_i,
  input  logic               pop_i,
  output jtm_pkg::out_item_t head_o,
  output logic               not_empty_o,
  output logic               no_room_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] RoomMark = CntW'(Depth - 2);

  jtm_pkg::out_item_t mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, wr_ptr1, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_ptr1 = ptr_inc(wr_ptr_q);

  // Pointer and fill level update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_i.push1) begin
      wr_ptr_d = ptr_inc(wr_ptr1);
    end else if (push_i.push0) begin
      wr_ptr_d = wr_ptr1;
    end
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i.push0) + CntW'(push_i.push1) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.push1) begin
      mem_q[wr_ptr1] <= push_i.res1;
    end
  end

  assign head_o      = mem_q[rd_ptr_q];
  assign not_empty_o = (count_q != '0);
  // room for two more results is needed before a byte is taken
  assign no_room_o   = (count_q > RoomMark);

endmodule

// ===== hw/rtl/json_text_minifier_top.sv =====
`timescale 1ns / 1ps
// Top level of the JSON text minifier: mode and count registers, byte scanner,
// result queue. Depends on jtm_pkg, jtm_scan and jtm_outq.
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o    in_item_i  (jtm_pkg::in_item_t)
//  out      output     out_valid_o / out_stall_i  out_item_o (jtm_pkg::out_item_t)
//
// One byte is taken per cycle unless in_stall_o is high; its results enter the queue at
// the same edge and can leave in the next cycle. A byte that follows a held slash may
// give two results; the queue drains one result per cycle while out_stall_i is low.
// in_stall_o rises when fewer than two queue entries are free (queue depth OutqDepth).
// Reset (rst_ni low, asynchronous) empties the queue, sets normal text mode and
// clears the kept count. out_stall_i only holds the queue head in place.

module json_text_minifier_top #(
  parameter int unsigned MaxTextLength = jtm_pkg::MaxTextLengthDef,
  parameter int unsigned OutqDepth     = jtm_pkg::OutqDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  jtm_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output jtm_pkg::out_item_t out_item_o
);

  jtm_pkg::mode_e             mode_q, mode_d, scan_mode;
  logic [jtm_pkg::CountW-1:0] total_q, total_d, scan_total;
  jtm_pkg::scan_res_t         scan_res, push;
  logic                       in_xfer, out_xfer, no_room;

  assign in_xfer  = in_valid_i && !no_room;
  assign out_xfer = out_valid_o && !out_stall_i;

  jtm_scan #(
    .MaxTextLength(MaxTextLength)
  ) u_scan (
    .mode_q_i (mode_q),
    .total_q_i(total_q),
    .item_i   (in_item_i),
    .mode_d_o (scan_mode),
    .total_d_o(scan_total),
    .res_o    (scan_res)
  );

  // Results only enter the queue on an input transfer
  always_comb begin
    push       = scan_res;
    push.push0 = scan_res.push0 && in_xfer;
    push.push1 = scan_res.push1 && in_xfer;
    mode_d     = in_xfer ? scan_mode  : mode_q;
    total_d    = in_xfer ? scan_total : total_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= jtm_pkg::MODE_NORMAL;
      total_q <= '0;
    end else begin
      mode_q  <= mode_d;
      total_q <= total_d;
    end
  end

  jtm_outq #(
    .Depth(OutqDepth)
  ) u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pop_i      (out_xfer),
    .head_o     (out_item_o),
    .not_empty_o(out_valid_o),
    .no_room_o  (no_room)
  );

  assign in_stall_o = no_room;

endmodule

// ===== hw/rtl/jtm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the JSON text minifier, bound to the top level.
// Depends on jtm_pkg and json_text_minifier_top.

module jtm_bind_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input jtm_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input jtm_pkg::out_item_t out_item_o
);

  // A stalled byte stays offered and unchanged by the sender
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("stalled input byte changed or dropped");

  // A stalled result stays offered and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or dropped");

  // An empty result carries a zero byte
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_item_o.has_byte |-> out_item_o.out_byte == '0)
    else $error("empty result with nonzero byte");

  // Only the end of a buffer gives a result without a byte
  a_empty_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_item_o.has_byte |-> out_item_o.done_res)
    else $error("empty result that does not close a buffer");

  // A kept byte always counts at least itself
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_item_o.has_byte |-> out_item_o.kept_count != '0)
    else $error("kept byte with zero count");

endmodule

bind json_text_minifier_top jtm_bind_checker u_jtm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_item_i  (in_item_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);

// ===== dv/jtm_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the JSON text minifier: watches both channels, predicts the
// results of every input transfer and compares them in order. Depends on jtm_pkg.

module jtm_checker #(
  parameter int unsigned MaxTextLength = jtm_pkg::MaxTextLengthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  jtm_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  jtm_pkg::out_item_t out_item_i,
  input  logic               flush_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        checked_o,
  output int unsigned        stops_o,
  output int unsigned        saturated_o
);
  import jtm_pkg::*;

  localparam logic [CountW-1:0] KeepLimit =
    (MaxTextLength < 65535) ? CountW'(MaxTextLength) : {CountW{1'b1}};

  // Predictor state
  mode_e             scan_mode_q;
  logic [CountW-1:0] kept_q;

  // Results still owed by the block, oldest first
  out_item_t         expected_q[$];
  out_item_t         step_res[2];
  int                step_n;
  bit                flushed;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    fail_count_o++;
  endtask

  // Keep one byte: bump the saturating count and stage a result
  task automatic keep_byte(input logic [ByteW-1:0] b);
    if (kept_q < KeepLimit) kept_q++;
    else saturated_o++;
    step_res[step_n] = '{has_byte: 1'b1, out_byte: b, done_res: 1'b0, kept_count: kept_q};
    step_n++;
  endtask

  task automatic plain_text_byte(input logic [ByteW-1:0] b);
    case (b)
      CharNul: scan_mode_q = MODE_STOP;
      CharSpace, CharTab, CharCr, CharLf: ;
      CharSlash: scan_mode_q = MODE_SLASH;
      CharQuote: begin
        keep_byte(b);
        scan_mode_q = MODE_STR;
      end
      default: keep_byte(b);
    endcase
  endtask

  // Expected results of one input transfer
  task automatic minify_byte(input in_item_t it);
    logic [ByteW-1:0] b;
    mode_e            prev_mode;
    b = it.in_byte;
    prev_mode = scan_mode_q;
    step_n = 0;
    case (scan_mode_q)
      MODE_NORMAL: plain_text_byte(b);
      MODE_SLASH: begin
        if (b == CharSlash) scan_mode_q = MODE_LINE;
        else if (b == CharStar) scan_mode_q = MODE_BLOCK;
        else begin
          // held slash goes out first, then the byte is plain text
          keep_byte(CharSlash);
          scan_mode_q = MODE_NORMAL;
          plain_text_byte(b);
        end
      end
      MODE_LINE: begin
        if (b == CharNul) scan_mode_q = MODE_STOP;
        else if (b == CharLf) scan_mode_q = MODE_NORMAL;
      end
      MODE_BLOCK: begin
        if (b == CharNul) scan_mode_q = MODE_STOP;
        else if (b == CharStar) scan_mode_q = MODE_BSTAR;
      end
      MODE_BSTAR: begin
        if (b == CharNul) scan_mode_q = MODE_STOP;
        else if (b == CharSlash) scan_mode_q = MODE_NORMAL;
        else if (b != CharStar) scan_mode_q = MODE_BLOCK;
      end
      MODE_STR: begin
        if (b == CharNul) scan_mode_q = MODE_STOP;
        else begin
          keep_byte(b);
          if (b == CharBackslash) scan_mode_q = MODE_SESC;
          else if (b == CharQuote) scan_mode_q = MODE_NORMAL;
        end
      end
      MODE_SESC: begin
        keep_byte(b);
        scan_mode_q = MODE_STR;
      end
      default: ;
    endcase
    if (scan_mode_q == MODE_STOP && prev_mode != MODE_STOP) stops_o++;

    // Final byte: flush a held slash, always close with a done result
    if (it.last_byte) begin
      if (scan_mode_q == MODE_SLASH) keep_byte(CharSlash);
      if (step_n == 0) begin
        step_res[0] = '{has_byte: 1'b0, out_byte: '0, done_res: 1'b0, kept_count: kept_q};
        step_n = 1;
      end
      step_res[step_n-1].done_res = 1'b1;
      scan_mode_q = MODE_NORMAL;
      kept_q = '0;
    end
    for (int i = 0; i < step_n; i++) expected_q.push_back(step_res[i]);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t exp;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result %h with nothing expected", got));
      return;
    end
    exp = expected_q.pop_front();
    checked_o++;
    if (got.has_byte !== exp.has_byte)
      report_mismatch($sformatf("has_byte %b, expected %b", got.has_byte, exp.has_byte));
    if (got.out_byte !== exp.out_byte)
      report_mismatch($sformatf("out_byte %h, expected %h", got.out_byte, exp.out_byte));
    if (got.done_res !== exp.done_res)
      report_mismatch($sformatf("done_res %b, expected %b", got.done_res, exp.done_res));
    if (got.kept_count !== exp.kept_count)
      report_mismatch($sformatf("kept_count %0d, expected %0d", got.kept_count,
                                exp.kept_count));
  endtask

  // Inputs are predicted before outputs are checked, both on the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_mode_q = MODE_NORMAL;
      kept_q = '0;
      expected_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) minify_byte(in_item_i);
      if (out_valid_i && !out_stall_i) check_result(out_item_i);
      if (flush_i && !flushed) begin
        flushed = 1'b1;
        if (expected_q.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// ===== dv/tb_json_text_minifier_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the JSON text minifier: clock, reset, byte stimulus and
// result-side stalls; checking is done by jtm_checker. Depends on jtm_pkg, json_text_minifier_top and jtm_checker.

module tb_json_text_minifier_top;
  import jtm_pkg::*;

  localparam int unsigned RandomBytes = 520;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        flush;
  bit          idle_en;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned stops;
  int unsigned saturated;
  int unsigned bytes_sent;
  int unsigned buffers_sent;
  int unsigned random_start;

  logic [ByteW-1:0] text_q[$];

  always #2 clk = ~clk;

  json_text_minifier_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  jtm_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .flush_i      (flush),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .stops_o      (stops),
    .saturated_o  (saturated)
  );

  // One input transfer, preceded by a random gap when idling is on
  task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_item = '{in_byte: b, last_byte: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
    if (last) buffers_sent++;
  endtask

  // Send the staged buffer; its final byte carries last_byte
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic append_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  function automatic logic [ByteW-1:0] pick_from(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // Hold off input until every owed result has left the block
  task automatic wait_drained();
    int unsigned n;
    in_valid = 1'b0;
    n = 0;
    while (pending != 0 && n < 5000) begin
      @(negedge clk);
      n++;
    end
  endtask

  // One JSON-like token; mostly well formed, some broken or noisy
  task automatic add_token();
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(0, 99);
    len = $urandom_range(0, 6);
    if (kind < 25) begin
      text_q.push_back(pick_from("{}[]:,-.0123456789eEtrufalsn"));
    end else if (kind < 38) begin
      case ($urandom_range(0, 3))
        0: text_q.push_back(CharSpace);
        1: text_q.push_back(CharTab);
        2: text_q.push_back(CharCr);
        default: text_q.push_back(CharLf);
      endcase
    end else if (kind < 58) begin
      // string; escapes may carry any byte, NUL included
      text_q.push_back(CharQuote);
      repeat (len) begin
        case ($urandom_range(0, 9))
          0: begin
            text_q.push_back(CharBackslash);
            text_q.push_back(8'($urandom_range(0, 255)));
          end
          1: text_q.push_back(pick_from("/*{} "));
          2: text_q.push_back(8'($urandom_range(1, 255)));
          default: text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        endcase
      end
      if ($urandom_range(0, 9) != 0) text_q.push_back(CharQuote);
    end else if (kind < 66) begin
      append_str("//");
      repeat (len) text_q.push_back(8'($urandom_range(1, 255)));
      if ($urandom_range(0, 7) != 0) text_q.push_back(CharLf);
    end else if (kind < 76) begin
      append_str("/*");
      repeat (len) text_q.push_back(pick_from("*/ab*\n"));
      if ($urandom_range(0, 7) != 0) append_str("*/");
    end else if (kind < 84) begin
      text_q.push_back(CharSlash);
    end else if (kind < 97) begin
      text_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      text_q.push_back(CharNul);
    end
  endtask

  task automatic send_random_buffer();
    int unsigned target;
    target = $urandom_range(1, 24);
    while (text_q.size() < target) add_token();
    send_text();
  endtask

  // Result side: random stall before each transfer
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      hold = idle_en ? $urandom_range(0, 11) : 0;
      if (hold != 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    flush = 1'b0;
    idle_en = 1'b1;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // whitespace, slash then another byte, top byte value, slash as final byte
    append_str(" \t");
    text_q.push_back(CharCr);
    text_q.push_back(CharLf);
    text_q.push_back(CharSlash);
    text_q.push_back(8'hFF);
    text_q.push_back(CharSlash);
    send_text();

    // slash-star-slash stays in the comment, double star closes it,
    // escaped NUL inside a string
    append_str("/*/**/\"\\");
    text_q.push_back(CharNul);
    append_str("\"");
    send_text();

    // line comment ends at LF, NUL in a string stops, final byte keeps nothing
    append_str("//\n\"");
    text_q.push_back(CharNul);
    append_str("b");
    send_text();

    // NUL inside a block comment as the final byte
    append_str("/*");
    text_q.push_back(CharNul);
    send_text();

    // NUL in plain text, then a dropped final byte
    text_q.push_back(CharNul);
    text_q.push_back(CharSpace);
    send_text();

    wait_drained();

    // random buffers, with quiet stretches and occasional full drains
    random_start = bytes_sent;
    while (bytes_sent - random_start < RandomBytes) begin
      idle_en = ($urandom_range(0, 5) != 0);
      send_random_buffer();
      if ($urandom_range(0, 15) == 0) wait_drained();
    end

    idle_en = 1'b1;
    wait_drained();
    repeat (20) @(negedge clk);
    flush = 1'b1;
    repeat (2) @(negedge clk);

    $display("Run covered %0d byte transfers in %0d buffers, %0d results checked.",
             bytes_sent, buffers_sent, checked);
    $display("Comments, strings, escapes, %0d NUL stops, %0d keeps at the count limit.",
             stops, saturated);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Run timed out.");
    $display("FAILURE");
    $finish;
  end

endmodule
